[hdl/sib_pkg.sv]
// Shared types and codes for the sorted insertion buffer.
`default_nettype none
package sib_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_INSERTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_DRAINED  = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    logic                     insert;
    logic                     shift;
    logic signed [DATA_W-1:0] val;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hdl/sib_cell.sv]
// One storage cell of the sorted chain: compare, hold, take from a neighbor.
`default_nettype none
module sib_cell (
  input  wire logic                             clk,
  input  wire sib_pkg::cell_ctrl_t              ctrl,
  input  wire logic                             occ,
  input  wire logic                             left_less,
  input  wire logic signed [sib_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [sib_pkg::DATA_W-1:0] right_data,
  output logic signed [sib_pkg::DATA_W-1:0]     data,
  output logic                                  less
);
  import sib_pkg::*;

  logic signed [DATA_W-1:0] data_next;

  assign less = occ && (data < ctrl.val);

  always_comb begin
    data_next = data;
    if (ctrl.shift) begin
      data_next = right_data;
    end else if (ctrl.insert && !less) begin
      data_next = left_less ? ctrl.val : left_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

[hdl/sorted_insertion_buffer.sv]
// Top level of the sorted insertion buffer: cell chain, fill count and result register.
//
// Commands enter on start/cmd/value and are taken at a clock edge where start
// is high and busy is low. An insert compares the value against every cell of
// the chain at once and shifts the larger entries one cell up, so inserts are
// taken back to back, one per cycle; its status beat (inserted, or rejected
// when the store already holds DEPTH values) appears on the result ports in the
// cycle after it is taken.
// A drain walks the chain down toward cell zero one entry per cycle and gives
// one beat per stored value in ascending order, last marking the final one;
// busy stays high until the last entry is shifted out, and each beat follows in
// the cycle after its shift. A drain of an empty store gives one beat of kind empty.
// Each beat is on kind/value_res/last for exactly one cycle, marked by strobe;
// the receiver cannot stall it.
// Synchronous reset empties the store and drops any beat or drain in flight.
`default_nettype none
module sorted_insertion_buffer #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cmd,
  input  wire logic signed [sib_pkg::DATA_W-1:0] value,
  output logic                                   strobe,
  output logic [1:0]                             kind,
  output logic signed [sib_pkg::DATA_W-1:0]      value_res,
  output logic                                   last
);
  import sib_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_t                   state;
  state_t                   state_next;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  cell_ctrl_t               ctrl;
  logic                     accept;
  logic                     full;
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic                     cell_less [DEPTH];
  logic                     strobe_next;
  kind_t                    kind_next;
  logic signed [DATA_W-1:0] value_res_next;
  logic                     last_next;

  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_DRAIN && count != '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (count == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state == ST_DRAIN);
    ctrl.insert    = accept && cmd == CMD_INSERT && !full;
    ctrl.shift     = (state == ST_DRAIN);
    ctrl.val       = value;
    count_next     = count;
    strobe_next    = 1'b0;
    kind_next      = KIND_INSERTED;
    value_res_next = '0;
    last_next      = 1'b1;
    if (ctrl.shift) begin
      count_next     = count - CW'(1);
      strobe_next    = 1'b1;
      kind_next      = KIND_DRAINED;
      value_res_next = cell_data[0];
      last_next      = (count == CW'(1));
    end else if (accept) begin
      if (cmd == CMD_INSERT) begin
        strobe_next = 1'b1;
        if (full) begin
          kind_next = KIND_REJECTED;
        end else begin
          count_next = count + CW'(1);
        end
      end else if (count == '0) begin
        strobe_next = 1'b1;
        kind_next   = KIND_EMPTY;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     occ;
    logic                     left_less;
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;

    assign occ = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign left_less = 1'b1;
      assign left_data = value;
    end else begin : g_body
      assign left_less = cell_less[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    sib_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ),
      .left_less  (left_less),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .less       (cell_less[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    kind      <= kind_next;
    value_res <= value_res_next;
    last      <= last_next;
  end

`ifndef SYNTHESIS
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (count != '0))
    else $error("drain running on an empty store");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_insert_beat: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_INSERT) |=> (strobe && last))
    else $error("insert gave no single status beat");

  a_drain_continues: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == KIND_DRAINED && !last) |-> busy)
    else $error("drain stopped before its last beat");
`endif

endmodule
`default_nettype wire
